// File: rtl/i2c_master_phase_sequencer_top_defines.svh
// Assertion macros for the I2C master phase sequencer.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef I2C_MASTER_PHASE_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_PHASE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define I2CPS_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("i2cps: implication check failed");

// Condition that must never hold at a rising clock edge outside reset.
`define I2CPS_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("i2cps: forbidden condition seen");

`else

`define I2CPS_ASSERT_IMPLY(lbl, pre, post)
`define I2CPS_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: rtl/i2cps_pkg.sv
package i2cps_pkg;

	// Command codes; the upper three are internal continuation phases.
	localparam logic [2:0] CMD_IDLE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_STOP    = 3'd2;
	localparam logic [2:0] CMD_WRITE   = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;
	localparam logic [2:0] CMD_ACKWAIT = 3'd5;
	localparam logic [2:0] CMD_TOSTOP  = 3'd6;
	localparam logic [2:0] CMD_ACKSEND = 3'd7;

	// Completion status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_BUS_ERR = 2'd2;
	localparam logic [1:0] ST_NO_ACK  = 2'd3;

	// Acknowledge wait limit after reset.
	localparam logic [7:0] ACK_WAIT_RESET = 8'd50;

	// Number of bits in one transferred byte.
	localparam logic [3:0] BYTE_BITS = 4'd8;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] phase;
		logic [3:0] bit_cnt;
		logic [7:0] shift;
		logic [7:0] wait_cnt;
		logic       ack_choice;
		logic       scl;
		logic       sda;
	} state_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
		logic       ready_res;
	} result_t;

endpackage

// File: rtl/i2cps_in_if.sv
interface i2cps_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] data_byte;
	logic       send_ack;
	logic       sda_level;

	modport source (output valid, output mode, output data_byte, output send_ack,
		output sda_level, input ready);
	modport sink (input valid, input mode, input data_byte, input send_ack,
		input sda_level, output ready);
endinterface

// File: rtl/i2cps_out_if.sv
interface i2cps_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] read_data;
	logic       ready_res;

	modport source (output valid, output scl_out, output sda_out, output done_res,
		output status, output read_data, output ready_res, input ready);
	modport sink (input valid, input scl_out, input sda_out, input done_res,
		input status, input read_data, input ready_res, output ready);
endinterface

// File: rtl/i2cps_step.sv
module i2cps_step
	import i2cps_pkg::*;
(
	input  state_t     cur,
	input  logic [2:0] mode,
	input  logic [7:0] data_byte,
	input  logic       send_ack,
	input  logic       sda_level,
	input  logic [7:0] ack_wait_limit,
	output state_t     nxt,
	output result_t    res
);

	logic       done;
	logic [1:0] stat;
	logic [7:0] rd;
	logic [3:0] bit_inc;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		stat = ST_OK;
		rd   = 8'd0;

		// A command is taken only while idle and acts in the same slot.
		if (cur.cmd == CMD_IDLE && mode >= CMD_START && mode <= CMD_READ) begin
			nxt.cmd        = mode;
			nxt.phase      = 3'd0;
			nxt.bit_cnt    = 4'd0;
			nxt.wait_cnt   = 8'd0;
			nxt.shift      = (mode == CMD_WRITE) ? data_byte : 8'd0;
			nxt.ack_choice = send_ack;
		end

		bit_inc = nxt.bit_cnt + 4'd1;

		// One pin action per slot, selected by command and phase.
		unique case (nxt.cmd)
			CMD_IDLE: begin
			end
			CMD_START: begin
				unique case (nxt.phase)
					3'd0: begin nxt.sda = 1'b1; nxt.phase = 3'd1; end
					3'd1: begin nxt.scl = 1'b1; nxt.phase = 3'd2; end
					3'd2: begin
						if (!sda_level) begin
							done = 1'b1; stat = ST_BUSY;
						end else begin
							nxt.phase = 3'd3;
						end
					end
					3'd3: begin nxt.sda = 1'b0; nxt.phase = 3'd4; end
					3'd4: begin
						if (sda_level) begin
							done = 1'b1; stat = ST_BUS_ERR;
						end else begin
							nxt.phase = 3'd5;
						end
					end
					3'd5: begin nxt.scl = 1'b0; done = 1'b1; end
					default: begin nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; end
				endcase
			end
			CMD_STOP, CMD_TOSTOP: begin
				unique case (nxt.phase)
					3'd0: begin nxt.scl = 1'b0; nxt.phase = 3'd1; end
					3'd1: begin nxt.sda = 1'b0; nxt.phase = 3'd2; end
					3'd2: begin nxt.scl = 1'b1; nxt.phase = 3'd3; end
					3'd3: begin
						nxt.sda = 1'b1;
						done    = 1'b1;
						stat    = (nxt.cmd == CMD_TOSTOP) ? ST_NO_ACK : ST_OK;
					end
					default: begin nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; end
				endcase
			end
			CMD_WRITE: begin
				unique case (nxt.phase)
					3'd0: begin nxt.scl = 1'b0; nxt.phase = 3'd1; end
					3'd1: begin
						nxt.sda   = nxt.shift[7];
						nxt.shift = {nxt.shift[6:0], 1'b0};
						nxt.phase = 3'd2;
					end
					3'd2: begin
						nxt.scl     = 1'b1;
						nxt.bit_cnt = bit_inc;
						nxt.phase   = (bit_inc >= BYTE_BITS) ? 3'd3 : 3'd0;
					end
					3'd3: begin
						nxt.scl      = 1'b0;
						nxt.cmd      = CMD_ACKWAIT;
						nxt.phase    = 3'd0;
						nxt.wait_cnt = 8'd0;
					end
					default: begin nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; end
				endcase
			end
			CMD_ACKWAIT: begin
				unique case (nxt.phase)
					3'd0: begin nxt.scl = 1'b0; nxt.phase = 3'd1; end
					3'd1: begin nxt.sda = 1'b1; nxt.phase = 3'd2; end
					3'd2: begin nxt.scl = 1'b1; nxt.phase = 3'd3; end
					3'd3: begin
						// Low SDA is the acknowledge; high samples count toward timeout.
						priority if (!sda_level) begin
							nxt.phase = 3'd4;
						end else if (nxt.wait_cnt >= ack_wait_limit) begin
							nxt.cmd   = CMD_TOSTOP;
							nxt.phase = 3'd0;
						end else begin
							nxt.wait_cnt = nxt.wait_cnt + 8'd1;
						end
					end
					3'd4: begin nxt.scl = 1'b0; done = 1'b1; end
					default: begin nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; end
				endcase
			end
			CMD_READ: begin
				unique case (nxt.phase)
					3'd0: begin nxt.sda = 1'b1; nxt.phase = 3'd1; end
					3'd1: begin nxt.scl = 1'b0; nxt.phase = 3'd2; end
					3'd2: begin nxt.scl = 1'b1; nxt.phase = 3'd3; end
					3'd3: begin
						nxt.shift   = {nxt.shift[6:0], sda_level};
						nxt.bit_cnt = bit_inc;
						nxt.phase   = (bit_inc >= BYTE_BITS) ? 3'd4 : 3'd1;
					end
					3'd4: begin
						nxt.scl   = 1'b0;
						nxt.cmd   = CMD_ACKSEND;
						nxt.phase = 3'd0;
					end
					default: begin nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; end
				endcase
			end
			CMD_ACKSEND: begin
				unique case (nxt.phase)
					3'd0: begin nxt.scl = 1'b0; nxt.phase = 3'd1; end
					3'd1: begin nxt.sda = ~nxt.ack_choice; nxt.phase = 3'd2; end
					3'd2: begin nxt.scl = 1'b1; nxt.phase = 3'd3; end
					3'd3: begin nxt.scl = 1'b0; rd = nxt.shift; done = 1'b1; end
					default: begin nxt.cmd = CMD_IDLE; nxt.phase = 3'd0; end
				endcase
			end
		endcase

		// A finished command returns to idle.
		if (done) begin
			nxt.cmd   = CMD_IDLE;
			nxt.phase = 3'd0;
		end
	end

	// Result of this slot.
	always_comb begin
		res.scl_out   = nxt.scl;
		res.sda_out   = nxt.sda;
		res.done_res  = done;
		res.status    = stat;
		res.read_data = rd;
		res.ready_res = (nxt.cmd == CMD_IDLE);
	end

endmodule

// File: rtl/i2c_master_phase_sequencer_top.sv
// Channel   Role    Beat carries
// cmd       sink    mode, data_byte, send_ack, sda_level (one pin slot)
// res       source  scl_out, sda_out, done_res, status, read_data, ready_res
// cfg       write   cfg_wdata -> ack_wait_limit when cfg_we is high
//
// One cmd beat yields one res beat, one beat per cycle sustained while res is ready.
// The slot's state update and result are computed combinationally into the
// result register; cmd is taken whenever that register is empty or drained.
// A stalled res holds its beat and blocks cmd until it is taken.
// arst_n clears the sequencer to idle with both lines released, limit 50.
`include "i2c_master_phase_sequencer_top_defines.svh"

module i2c_master_phase_sequencer_top
	import i2cps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2cps_in_if.sink    cmd,
	i2cps_out_if.source res,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	state_t     state_q;
	state_t     state_nxt;
	result_t    res_q;
	result_t    res_nxt;
	logic       res_valid_q;
	logic [7:0] limit_q;
	logic       take;

	// A beat is taken when the result register is free or being emptied.
	assign cmd.ready = !res_valid_q || res.ready;
	assign take      = cmd.valid && cmd.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ACK_WAIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	i2cps_step u_step (
		.cur            (state_q),
		.mode           (cmd.mode),
		.data_byte      (cmd.data_byte),
		.send_ack       (cmd.send_ack),
		.sda_level      (cmd.sda_level),
		.ack_wait_limit (limit_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// Sequencer state advances once per accepted slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{cmd: CMD_IDLE, phase: 3'd0, bit_cnt: 4'd0, shift: 8'd0,
				wait_cnt: 8'd0, ack_choice: 1'b0, scl: 1'b1, sda: 1'b1};
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.scl_out   = res_q.scl_out;
	assign res.sda_out   = res_q.sda_out;
	assign res.done_res  = res_q.done_res;
	assign res.status    = res_q.status;
	assign res.read_data = res_q.read_data;
	assign res.ready_res = res_q.ready_res;

	// A finished command always leaves the sequencer idle.
	`I2CPS_ASSERT_IMPLY(a_done_idle, res_valid_q && res_q.done_res, res_q.ready_res)
	// Status and read data stay zero in slots that finish nothing.
	`I2CPS_ASSERT_IMPLY(a_quiet_slot, res_valid_q && !res_q.done_res,
		res_q.status == ST_OK && res_q.read_data == 8'd0)
	// The reported idle flag matches the stored command.
	`I2CPS_ASSERT_IMPLY(a_idle_match, res_valid_q,
		res_q.ready_res == (state_q.cmd == CMD_IDLE))
	// A slot never overwrites a result that is still waiting.
	`I2CPS_ASSERT_NEVER(a_no_overrun, take && res_valid_q && !res.ready)

endmodule

// File: verif/tb_i2c_master_phase_sequencer_top.sv
`timescale 1ns / 1ps

module tb_i2c_master_phase_sequencer_top
	import i2cps_pkg::*;
;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	i2cps_in_if  cmd_ch();
	i2cps_out_if res_ch();

	i2c_master_phase_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the sequencer state and its acknowledge wait limit.
	logic [2:0] bus_cmd;
	logic [2:0] bus_phase;
	logic [3:0] bus_bits;
	logic [7:0] bus_shift;
	logic [7:0] bus_wait;
	logic       bus_ack;
	logic       bus_scl;
	logic       bus_sda;
	logic [7:0] bus_limit;

	result_t expected_slots[$];
	logic    sda_plan[$];

	int err_count;
	int slot_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Advance the shadow sequencer by one pin slot and form the expected beat.
	task automatic predict_pin_slot(input logic [2:0] mode, input logic [7:0] data,
		input logic ack, input logic sda, output result_t slot_res);
		logic       done;
		logic [1:0] st;
		logic [7:0] rd;
		done = 1'b0;
		st = ST_OK;
		rd = 8'h00;
		if (bus_cmd == CMD_IDLE && mode >= CMD_START && mode <= CMD_READ) begin
			bus_cmd = mode;
			bus_phase = 3'd0;
			bus_bits = 4'd0;
			bus_wait = 8'd0;
			bus_shift = (mode == CMD_WRITE) ? data : 8'h00;
			bus_ack = ack;
		end
		case (bus_cmd)
			CMD_IDLE: ;
			CMD_START: begin
				case (bus_phase)
					3'd0: begin bus_sda = 1'b1; bus_phase = 3'd1; end
					3'd1: begin bus_scl = 1'b1; bus_phase = 3'd2; end
					3'd2: begin
						if (!sda) begin
							done = 1'b1;
							st = ST_BUSY;
						end else begin
							bus_phase = 3'd3;
						end
					end
					3'd3: begin bus_sda = 1'b0; bus_phase = 3'd4; end
					3'd4: begin
						if (sda) begin
							done = 1'b1;
							st = ST_BUS_ERR;
						end else begin
							bus_phase = 3'd5;
						end
					end
					3'd5: begin bus_scl = 1'b0; done = 1'b1; end
					default: begin bus_cmd = CMD_IDLE; bus_phase = 3'd0; end
				endcase
			end
			CMD_STOP, CMD_TOSTOP: begin
				case (bus_phase)
					3'd0: begin bus_scl = 1'b0; bus_phase = 3'd1; end
					3'd1: begin bus_sda = 1'b0; bus_phase = 3'd2; end
					3'd2: begin bus_scl = 1'b1; bus_phase = 3'd3; end
					3'd3: begin
						bus_sda = 1'b1;
						done = 1'b1;
						st = (bus_cmd == CMD_TOSTOP) ? ST_NO_ACK : ST_OK;
					end
					default: begin bus_cmd = CMD_IDLE; bus_phase = 3'd0; end
				endcase
			end
			CMD_WRITE: begin
				case (bus_phase)
					3'd0: begin bus_scl = 1'b0; bus_phase = 3'd1; end
					3'd1: begin
						bus_sda = bus_shift[7];
						bus_shift = {bus_shift[6:0], 1'b0};
						bus_phase = 3'd2;
					end
					3'd2: begin
						bus_scl = 1'b1;
						bus_bits = bus_bits + 4'd1;
						bus_phase = (bus_bits >= BYTE_BITS) ? 3'd3 : 3'd0;
					end
					3'd3: begin
						bus_scl = 1'b0;
						bus_cmd = CMD_ACKWAIT;
						bus_phase = 3'd0;
						bus_wait = 8'd0;
					end
					default: begin bus_cmd = CMD_IDLE; bus_phase = 3'd0; end
				endcase
			end
			CMD_ACKWAIT: begin
				case (bus_phase)
					3'd0: begin bus_scl = 1'b0; bus_phase = 3'd1; end
					3'd1: begin bus_sda = 1'b1; bus_phase = 3'd2; end
					3'd2: begin bus_scl = 1'b1; bus_phase = 3'd3; end
					3'd3: begin
						if (!sda) begin
							bus_phase = 3'd4;
						end else if (bus_wait >= bus_limit) begin
							bus_cmd = CMD_TOSTOP;
							bus_phase = 3'd0;
						end else begin
							bus_wait = bus_wait + 8'd1;
						end
					end
					3'd4: begin bus_scl = 1'b0; done = 1'b1; end
					default: begin bus_cmd = CMD_IDLE; bus_phase = 3'd0; end
				endcase
			end
			CMD_READ: begin
				case (bus_phase)
					3'd0: begin bus_sda = 1'b1; bus_phase = 3'd1; end
					3'd1: begin bus_scl = 1'b0; bus_phase = 3'd2; end
					3'd2: begin bus_scl = 1'b1; bus_phase = 3'd3; end
					3'd3: begin
						bus_shift = {bus_shift[6:0], sda};
						bus_bits = bus_bits + 4'd1;
						bus_phase = (bus_bits >= BYTE_BITS) ? 3'd4 : 3'd1;
					end
					3'd4: begin
						bus_scl = 1'b0;
						bus_cmd = CMD_ACKSEND;
						bus_phase = 3'd0;
					end
					default: begin bus_cmd = CMD_IDLE; bus_phase = 3'd0; end
				endcase
			end
			CMD_ACKSEND: begin
				case (bus_phase)
					3'd0: begin bus_scl = 1'b0; bus_phase = 3'd1; end
					3'd1: begin bus_sda = ~bus_ack; bus_phase = 3'd2; end
					3'd2: begin bus_scl = 1'b1; bus_phase = 3'd3; end
					3'd3: begin bus_scl = 1'b0; rd = bus_shift; done = 1'b1; end
					default: begin bus_cmd = CMD_IDLE; bus_phase = 3'd0; end
				endcase
			end
			default: begin bus_cmd = CMD_IDLE; bus_phase = 3'd0; end
		endcase
		// A finished command always returns to idle.
		if (done) begin
			bus_cmd = CMD_IDLE;
			bus_phase = 3'd0;
		end
		slot_res.scl_out = bus_scl;
		slot_res.sda_out = bus_sda;
		slot_res.done_res = done;
		slot_res.status = st;
		slot_res.read_data = done ? rd : 8'h00;
		slot_res.ready_res = (bus_cmd == CMD_IDLE);
	endtask

	// Choose the SDA level for the next slot; planned levels go to sample slots only.
	function automatic logic pick_sda_level();
		logic sampling;
		sampling = (bus_cmd == CMD_START && (bus_phase == 3'd2 || bus_phase == 3'd4)) ||
			(bus_cmd == CMD_ACKWAIT && bus_phase == 3'd3) ||
			(bus_cmd == CMD_READ && bus_phase == 3'd3);
		if (sampling && sda_plan.size() > 0)
			return sda_plan.pop_front();
		if (bus_cmd == CMD_START && bus_phase == 3'd2)
			return $urandom_range(9) != 0;
		if (bus_cmd == CMD_START && bus_phase == 3'd4)
			return $urandom_range(9) == 0;
		if (bus_cmd == CMD_ACKWAIT && bus_phase == 3'd3)
			return $urandom_range(3) != 0;
		return 1'($urandom_range(1));
	endfunction

	// Offer one pin slot, wait for it to be taken and record its expected beat.
	task automatic send_pin_slot(input logic [2:0] mode, input logic [7:0] data,
		input logic ack, input logic sda);
		result_t slot_res;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= mode;
		cmd_ch.data_byte <= data;
		cmd_ch.send_ack <= ack;
		cmd_ch.sda_level <= sda;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_pin_slot(mode, data, ack, sda, slot_res);
		expected_slots.push_back(slot_res);
		slot_count++;
	endtask

	// Issue a command and feed slots with noise on the command fields until it ends.
	task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic ack);
		send_pin_slot(op, data, ack, pick_sda_level());
		while (bus_cmd != CMD_IDLE)
			send_pin_slot(3'($urandom), 8'($urandom), 1'($urandom), pick_sda_level());
	endtask

	// Slot while idle that carries no command: none or a code above read.
	task automatic send_idle_slot();
		logic [2:0] m;
		m = ($urandom_range(3) == 0) ? CMD_IDLE : 3'(CMD_READ + 1 + $urandom_range(2));
		send_pin_slot(m, 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic plan_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--)
			sda_plan.push_back(b[i]);
	endtask

	// Stop offering beats and wait until every expected beat has come back.
	task automatic drain_results();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_slots.size() > 0)
			@(posedge clk);
	endtask

	task automatic set_ack_limit(input logic [7:0] value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		bus_limit = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			err_count++;
		end
	endtask

	// Receiver readiness, with a counted hold-off that overrides random stalls.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			res_ch.ready <= 1'b0;
			hold_off_cycles--;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result beat with the oldest expected one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_slots.size() == 0) begin
				$error("result beat with no expected beat waiting");
				err_count++;
			end else begin
				want = expected_slots.pop_front();
				check_field("scl_out", want.scl_out, res_ch.scl_out);
				check_field("sda_out", want.sda_out, res_ch.sda_out);
				check_field("done_res", want.done_res, res_ch.done_res);
				check_field("status", want.status, res_ch.status);
				check_field("read_data", want.read_data, res_ch.read_data);
				check_field("ready_res", want.ready_res, res_ch.ready_res);
			end
		end
	end

	// Idle slots right after reset, including codes that are not commands.
	task automatic test_idle_slots();
		send_pin_slot(CMD_IDLE, 8'h00, 1'b0, 1'b0);
		send_pin_slot(3'(CMD_READ + 1), 8'hFF, 1'b1, 1'b1);
		send_pin_slot(3'(CMD_READ + 2), 8'h00, 1'b0, 1'b0);
		send_pin_slot(3'(CMD_READ + 3), 8'hFF, 1'b1, 1'b1);
	endtask

	// Start: clean, bus held low before, and SDA not following the drive.
	task automatic test_start();
		sda_plan = '{1'b1, 1'b0};
		run_command(CMD_START, 8'h00, 1'b0);
		sda_plan = '{1'b0};
		run_command(CMD_START, 8'hFF, 1'b1);
		sda_plan = '{1'b1, 1'b1};
		run_command(CMD_START, 8'h00, 1'b0);
	endtask

	task automatic test_stop();
		run_command(CMD_STOP, 8'hFF, 1'b1);
	endtask

	// Writes acknowledged at once and after a few high samples.
	task automatic test_write_ack();
		sda_plan = '{1'b0};
		run_command(CMD_WRITE, 8'hFF, 1'b0);
		sda_plan = '{1'b1, 1'b1, 1'b0};
		run_command(CMD_WRITE, 8'h00, 1'b1);
	endtask

	// Acknowledge timeout at the smallest limit and at limit 254.
	task automatic test_ack_timeout();
		set_ack_limit(8'd0);
		sda_plan = '{1'b1};
		run_command(CMD_WRITE, 8'hA5, 1'b0);
		set_ack_limit(8'd254);
		sda_plan.delete();
		repeat (255) sda_plan.push_back(1'b1);
		run_command(CMD_WRITE, 8'h5A, 1'b1);
		// The limit itself still lets a late acknowledge through.
		repeat (254) sda_plan.push_back(1'b1);
		sda_plan.push_back(1'b0);
		run_command(CMD_WRITE, 8'h3C, 1'b0);
	endtask

	// Reads ending in ACK and in NACK.
	task automatic test_read();
		plan_byte(8'hFF);
		run_command(CMD_READ, 8'h00, 1'b1);
		plan_byte(8'h00);
		run_command(CMD_READ, 8'hFF, 1'b0);
		plan_byte(8'hA5);
		run_command(CMD_READ, 8'h5A, 1'b1);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_back_pressure();
		drain_results();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 80;
		run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
		run_command(CMD_READ, 8'($urandom), 1'($urandom));
	endtask

	// Random commands with random content, mixed with idle noise slots.
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input logic [7:0] limit, input int slots);
		int first;
		int pick;
		set_ack_limit(limit);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		first = slot_count;
		while (slot_count - first < slots) begin
			pick = $urandom_range(99);
			if (pick < 8)
				send_idle_slot();
			else if (pick < 30)
				run_command(CMD_START, 8'($urandom), 1'($urandom));
			else if (pick < 48)
				run_command(CMD_STOP, 8'($urandom), 1'($urandom));
			else if (pick < 75)
				run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
			else
				run_command(CMD_READ, 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = CMD_IDLE;
		cmd_ch.data_byte = 8'h00;
		cmd_ch.send_ack = 1'b0;
		cmd_ch.sda_level = 1'b1;
		res_ch.ready = 1'b0;
		err_count = 0;
		slot_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		bus_cmd = CMD_IDLE;
		bus_phase = 3'd0;
		bus_bits = 4'd0;
		bus_shift = 8'h00;
		bus_wait = 8'h00;
		bus_ack = 1'b0;
		bus_scl = 1'b1;
		bus_sda = 1'b1;
		bus_limit = ACK_WAIT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_slots();
		test_start();
		test_stop();
		test_write_ack();
		test_read();
		test_ack_timeout();
		test_back_pressure();
		test_random_traffic(0, 0, ACK_WAIT_RESET, 45);
		test_random_traffic(78, 0, 8'd3, 45);
		test_random_traffic(0, 78, 8'($urandom_range(8)), 45);
		test_random_traffic(21, 21, 8'd1, 45);

		drain_results();
		repeat (5) @(posedge clk);
		if (err_count == 0 && expected_slots.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
